// ===== hw/rtl/gtg_pkg.sv =====
package gtg_pkg;

  localparam int CordicSteps = 16;
  localparam int CntW        = 5;
  localparam int DistW       = 16;
  localparam int NumW        = DistW + 10;
  localparam int DivW        = 17;
  localparam int AngW        = 20;
  localparam int CorW        = 28;

  localparam logic [1:0] CfgHeadingGain  = 2'd0;
  localparam logic [1:0] CfgArriveRadius = 2'd1;
  localparam logic [1:0] CfgMinDivisor   = 2'd2;

  localparam logic [11:0] HeadingGainRst  = 12'd1280;
  localparam logic [14:0] ArriveRadiusRst = 15'd102;
  localparam logic [11:0] MinDivisorRst   = 12'd128;

  localparam logic signed [AngW-1:0] HalfPi = 20'sd102944;

  typedef struct packed {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic               goal_known;
    logic [7:0]         customer_count;
  } req_t;

  typedef struct packed {
    logic               drive_valid;
    logic signed [15:0] turn_rate;
    logic [16:0]        forward_speed;
    logic               order_request;
    logic               carrying;
  } res_t;

  typedef enum logic [3:0] {
    StIdle, StSqX, StSqY, StRad, StDecide, StSqrt, StCordic, StGain, StDiv, StOut
  } state_e;

  // Arctangent of 2^-i in Q3.16 radians.
  function automatic logic signed [AngW-1:0] atan_lut(input logic [CntW-1:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30385;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/gtg_if.sv =====
interface gtg_req_if;
  logic             valid;
  logic             ready;
  gtg_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gtg_res_if;
  logic             valid;
  logic             ready;
  gtg_pkg::res_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/go_to_goal_steering_controller.sv =====
// A tick without customers, a first order or an arrival passes StSqX, StSqY, StRad, StDecide
// and StOut; a steering tick runs StSqrt (square root, one step per result bit), StCordic
// (angle, CordicSteps steps), StGain and StDiv (speed division, one step per quotient bit).
// One request is in flight at a time; the next is taken only once the result sits in the
// output register, and StOut holds while the output register is full and not taken.
// Reset (asynchronous, active low) restores the register defaults and arms the first order.
module go_to_goal_steering_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  gtg_req_if.sink     req_in,
  gtg_res_if.source   res_out,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);
  import gtg_pkg::*;

  // Configuration registers.
  logic [11:0] gain_q;
  logic [14:0] radius_q;
  logic [11:0] min_div_q;

  // Delivery sequencing state.
  logic has_drink_q, has_drink_d;
  logic awaiting_q, awaiting_d;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Captured request.
  logic signed [15:0] x_q, x_d, y_q, y_d;
  logic known_q, known_d, cust_q, cust_d;

  // Working registers of the shared datapath.
  logic [31:0] acc_q, acc_d;          // x*x + y*y, then square root remainder
  logic [29:0] r2_q, r2_d;
  logic [31:0] root_q, root_d;
  logic signed [CorW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [AngW-1:0] z_q, z_d;
  logic signed [15:0] rate_q, rate_d;
  logic [DivW-1:0] div_q, div_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;

  // Result staging and output register.
  res_t res_q, res_d;
  res_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  // The single shared multiplier: squares, radius squared and gain times angle.
  logic signed [16:0] mul_a;
  logic signed [AngW-1:0] mul_b;
  logic signed [36:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StSqX: begin
        mul_a = 17'(x_q);
        mul_b = AngW'(x_q);
      end
      StSqY: begin
        mul_a = 17'(y_q);
        mul_b = AngW'(y_q);
      end
      StRad: begin
        mul_a = {2'b00, radius_q};
        mul_b = {5'b00000, radius_q};
      end
      StGain: begin
        mul_a = {5'b00000, gain_q};
        mul_b = z_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = 37'(mul_a) * 37'(mul_b);
  end

  assign req_in.ready  = (state_q == StIdle);
  assign res_out.valid = out_valid_q;
  assign res_out.data  = out_q;

  // Temporaries of the sequencer.
  logic [31:0] sq_bit, sq_trial;
  logic signed [CorW-1:0] sh_x, sh_y, x256, y256;
  logic signed [37:0] rounded;
  logic signed [23:0] full;
  logic [DivW-1:0] mag, floor_div;
  logic [DivW:0] rem_sh;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    y_d         = y_q;
    known_d     = known_q;
    cust_d      = cust_q;
    acc_d       = acc_q;
    r2_d        = r2_q;
    root_d      = root_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    z_d         = z_q;
    rate_d      = rate_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    has_drink_d = has_drink_q;
    awaiting_d  = awaiting_q;

    sq_bit    = 32'(1) << (6'd30 - {cnt_q, 1'b0});
    sq_trial  = root_q + sq_bit;
    sh_x      = cx_q >>> cnt_q;
    sh_y      = cy_q >>> cnt_q;
    x256      = CorW'(x_q) <<< 8;
    y256      = CorW'(y_q) <<< 8;
    rounded   = 38'(prod) + 38'sd8192;
    full      = 24'(rounded >>> 14);
    mag       = full[23] ? DivW'(-full) : DivW'(full);
    floor_div = {3'b000, min_div_q, 2'b00};
    rem_sh    = {rem_q, quo_q[NumW-1]};

    if (res_out.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (req_in.valid) begin
          // An unknown goal is taken as a zero offset.
          x_d     = req_in.data.goal_known ? req_in.data.offset_x : 16'sd0;
          y_d     = req_in.data.goal_known ? req_in.data.offset_y : 16'sd0;
          known_d = req_in.data.goal_known;
          cust_d  = (req_in.data.customer_count != 8'd0);
          state_d = StSqX;
        end
      end
      StSqX: begin
        acc_d   = prod[31:0];
        state_d = StSqY;
      end
      StSqY: begin
        acc_d   = acc_q + prod[31:0];
        state_d = StRad;
      end
      StRad: begin
        r2_d    = prod[29:0];
        state_d = StDecide;
      end
      StDecide: begin
        res_d = '0;
        state_d = StOut;
        if (!cust_q) begin
          // No customers: nothing happens.
          res_d.carrying = has_drink_q;
        end else if (awaiting_q) begin
          res_d.order_request = 1'b1;
          awaiting_d          = 1'b0;
          res_d.carrying      = has_drink_q;
        end else if (acc_q <= {2'b00, r2_q}) begin
          // Arrival: pick up at the counter, or finish a delivery.
          res_d.drive_valid = 1'b1;
          if (!has_drink_q && known_q) begin
            has_drink_d    = 1'b1;
            res_d.carrying = 1'b1;
          end else begin
            has_drink_d         = 1'b0;
            res_d.order_request = 1'b1;
            res_d.carrying      = 1'b0;
          end
        end else begin
          res_d.drive_valid = 1'b1;
          res_d.carrying    = has_drink_q;
          root_d = '0;
          cnt_d  = '0;
          // Pre-rotate into the right half plane by a quarter turn.
          if (x_q < 0) begin
            if (y_q >= 0) begin
              cx_d = y256;
              cy_d = -x256;
              z_d  = HalfPi;
            end else begin
              cx_d = -y256;
              cy_d = x256;
              z_d  = -HalfPi;
            end
          end else begin
            cx_d = x256;
            cy_d = y256;
            z_d  = '0;
          end
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        // One result bit of the integer square root per cycle.
        if (acc_q >= sq_trial) begin
          acc_d  = acc_q - sq_trial;
          root_d = (root_q >> 1) + sq_bit;
        end else begin
          root_d = root_q >> 1;
        end
        if (cnt_q == CntW'(DistW - 1)) begin
          cnt_d   = '0;
          state_d = StCordic;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StCordic: begin
        if (cy_q > 0) begin
          cx_d = cx_q + sh_y;
          cy_d = cy_q - sh_x;
          z_d  = z_q + atan_lut(cnt_q);
        end else begin
          cx_d = cx_q - sh_y;
          cy_d = cy_q + sh_x;
          z_d  = z_q - atan_lut(cnt_q);
        end
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          cnt_d   = '0;
          state_d = StGain;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StGain: begin
        if (full > 24'sd32767) begin
          rate_d = 16'sd32767;
        end else if (full < -24'sd32768) begin
          rate_d = -16'sd32768;
        end else begin
          rate_d = 16'(full);
        end
        if (mag > floor_div) begin
          div_d = mag;
        end else if (floor_div == '0) begin
          div_d = DivW'(1);
        end else begin
          div_d = floor_div;
        end
        rem_d   = '0;
        quo_d   = {root_q[DistW-1:0], 10'b0};
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, div_q}) begin
          rem_d = DivW'(rem_sh - {1'b0, div_q});
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DivW-1:0];
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        if (cnt_q == CntW'(NumW - 1)) begin
          cnt_d   = '0;
          state_d = StOut;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StOut: begin
        if (!out_valid_q || res_out.ready) begin
          out_d = res_q;
          if (res_q.drive_valid && (cust_q && !awaiting_q) && state_q == StOut) begin
            out_d.turn_rate     = '0;
            out_d.forward_speed = '0;
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // The steering figures are filled in only when the division ran.
  logic steer_q, steer_d;
  always_comb begin
    steer_d = steer_q;
    if (state_q == StDecide) begin
      steer_d = 1'b0;
    end else if (state_q == StGain) begin
      steer_d = 1'b1;
    end
  end

  res_t out_fix;
  always_comb begin
    out_fix = out_d;
    if (state_q == StOut && (!out_valid_q || res_out.ready) && steer_q) begin
      out_fix.turn_rate     = rate_q;
      out_fix.forward_speed = (quo_q > NumW'(131071)) ? 17'd131071 : quo_q[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      has_drink_q <= 1'b0;
      awaiting_q  <= 1'b1;
      steer_q     <= 1'b0;
      gain_q      <= HeadingGainRst;
      radius_q    <= ArriveRadiusRst;
      min_div_q   <= MinDivisorRst;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      has_drink_q <= has_drink_d;
      awaiting_q  <= awaiting_d;
      steer_q     <= steer_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHeadingGain:  gain_q    <= cfg_data_i[11:0];
          CfgArriveRadius: radius_q  <= cfg_data_i;
          CfgMinDivisor:   min_div_q <= cfg_data_i[11:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    known_q <= known_d;
    cust_q  <= cust_d;
    acc_q   <= acc_d;
    r2_q    <= r2_d;
    root_q  <= root_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    z_q     <= z_d;
    rate_q  <= rate_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    res_q   <= res_d;
    out_q   <= out_fix;
  end

endmodule
